>>> sv/srx_pkg.sv
// Shared types, constants and the CRC-8 step function of the frame receiver.
package srx_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 8'd1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  // Reflected form of polynomial 0x31.
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  localparam int unsigned DESC_DEPTH = 2;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_TYPE  = 3'd3,
    PH_PAY   = 3'd4,
    PH_CRC   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] frame_type;
    logic [7:0] frame_length;
  } desc_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> sv/sync_len_type_crc8_frame_receiver.sv
// After the CRC byte, a good frame moves through header queue, read and result registers.
// Throughput in: one byte per cycle while full is low; full rises only while two checked
// frames await output. The back end takes up a new result only when no read is in flight
// and its single result register is empty; the payload memory read is registered.
// Reset: asynchronous, active low; parser hunts for the first sync byte, sync registers
// return to 0xAA and 0x55, header queue and result register are empty; no clearing pass.
module sync_len_type_crc8_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [srx_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    rx_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    frame_type_o,
  output logic [5:0]                    frame_length_o,
  output logic [4:0]                    byte_position_o,
  output logic [7:0]                    payload_value_o,
  output logic                          has_payload_o,
  output logic                          last_o
);
  import srx_pkg::*;

  localparam int unsigned IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic        accept;
  logic        desc_push, desc_pop, desc_valid, desc_full;
  desc_t       desc_in, desc_head;
  logic        wr_slot, rd_slot;
  logic        mem_we, mem_re;
  logic [IW:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign full        = desc_full;
  assign accept      = push && !desc_full;

  srx_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .IW         (IW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .wr_bank_i  (wr_slot),
    .desc_push_o(desc_push),
    .desc_o     (desc_in),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata)
  );

  srx_desc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (desc_push),
    .desc_i   (desc_in),
    .pop_i    (desc_pop),
    .full_o   (desc_full),
    .valid_o  (desc_valid),
    .desc_o   (desc_head),
    .wr_slot_o(wr_slot),
    .rd_slot_o(rd_slot)
  );

  srx_payload_ram #(
    .AW(IW + 1)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  srx_back #(
    .IW(IW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_valid_i   (desc_valid),
    .desc_i         (desc_head),
    .bank_i         (rd_slot),
    .desc_pop_o     (desc_pop),
    .re_o           (mem_re),
    .raddr_o        (mem_raddr),
    .rdata_i        (mem_rdata),
    .pop_i          (pop),
    .empty_o        (empty),
    .frame_type_o   (frame_type_o),
    .frame_length_o (frame_length_o),
    .byte_position_o(byte_position_o),
    .payload_value_o(payload_value_o),
    .has_payload_o  (has_payload_o),
    .last_o         (last_o)
  );

endmodule

>>> sv/srx_payload_ram.sv
// Two-bank payload memory: one write port, one registered read port.
module srx_payload_ram #(
  parameter int unsigned AW = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [2**AW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/srx_front.sv
// Front end: sync hunt, header parse, payload capture and CRC check.
module srx_front #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned IW          = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [srx_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          accept_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          wr_bank_i,
  output logic                          desc_push_o,
  output srx_pkg::desc_t                desc_o,
  output logic                          mem_we_o,
  output logic [IW:0]                   mem_waddr_o,
  output logic [7:0]                    mem_wdata_o
);
  import srx_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic [7:0] sync_first_q, sync_second_q;
  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] type_q, type_d;
  logic [7:0] fill_q, fill_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] crc_next;
  logic [7:0] fill_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SYNC_FIRST) begin
        sync_first_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_SYNC_SECOND) begin
        sync_second_q <= cfg_data_i;
      end
    end
  end

  assign crc_next = crc8_step(crc_q, rx_byte_i);
  assign fill_inc = fill_q + 8'd1;

  // Next state and parser registers.
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    type_d  = type_q;
    fill_d  = fill_q;
    crc_d   = crc_q;
    if (accept_i) begin
      case (phase_q)
        PH_SYNC2: begin
          phase_d = (rx_byte_i == sync_second_q) ? PH_LEN : PH_SYNC1;
        end
        PH_LEN: begin
          len_d   = rx_byte_i;
          fill_d  = '0;
          crc_d   = crc8_step(8'h00, rx_byte_i);
          phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          type_d = rx_byte_i;
          crc_d  = crc_next;
          if (len_q == 8'd0) begin
            phase_d = PH_CRC;
          end else if (len_q > MaxLen) begin
            phase_d = PH_SYNC1;
          end else begin
            phase_d = PH_PAY;
          end
        end
        PH_PAY: begin
          fill_d = fill_inc;
          crc_d  = crc_next;
          if (fill_inc >= len_q) begin
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          phase_d = PH_SYNC1;
        end
        default: begin
          phase_d = (rx_byte_i == sync_first_q) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

  // Outputs toward the payload memory and the descriptor queue.
  always_comb begin
    mem_we_o    = 1'b0;
    desc_push_o = 1'b0;
    case (phase_q)
      PH_PAY: begin
        mem_we_o = accept_i;
      end
      PH_CRC: begin
        desc_push_o = accept_i && (rx_byte_i == crc_q);
      end
      default: begin
        mem_we_o    = 1'b0;
        desc_push_o = 1'b0;
      end
    endcase
  end

  assign mem_waddr_o       = {wr_bank_i, fill_q[IW-1:0]};
  assign mem_wdata_o       = rx_byte_i;
  assign desc_o.frame_type   = type_q;
  assign desc_o.frame_length = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      len_q   <= '0;
      type_q  <= '0;
      fill_q  <= '0;
      crc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      type_q  <= type_d;
      fill_q  <= fill_d;
      crc_q   <= crc_d;
    end
  end

endmodule

>>> sv/srx_desc_queue.sv
// Two-entry queue of checked frame headers; the slot index selects the payload bank.
module srx_desc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srx_pkg::desc_t desc_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output srx_pkg::desc_t desc_o,
  output logic           wr_slot_o,
  output logic           rd_slot_o
);
  import srx_pkg::*;

  desc_t      entry_q [DESC_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign full_o    = (count_q == 2'(DESC_DEPTH));
  assign valid_o   = (count_q != 2'd0);
  assign desc_o    = entry_q[rd_ptr_q];
  assign wr_slot_o = wr_ptr_q;
  assign rd_slot_o = rd_ptr_q;

endmodule

>>> sv/srx_back.sv
// Back end: walks a checked frame out of the payload memory into the result register.
module srx_back #(
  parameter int unsigned IW = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           desc_valid_i,
  input  srx_pkg::desc_t desc_i,
  input  logic           bank_i,
  output logic           desc_pop_o,
  output logic           re_o,
  output logic [IW:0]    raddr_o,
  input  logic [7:0]     rdata_i,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     frame_type_o,
  output logic [5:0]     frame_length_o,
  output logic [4:0]     byte_position_o,
  output logic [7:0]     payload_value_o,
  output logic           has_payload_o,
  output logic           last_o
);
  import srx_pkg::*;

  logic [7:0] idx_q;
  logic       pend_q;
  logic       issue;
  logic       is_last;
  logic       has_pay;

  // Side data of the read in flight.
  logic [7:0] p_type_q;
  logic [5:0] p_len_q;
  logic [4:0] p_pos_q;
  logic       p_has_q;
  logic       p_last_q;

  logic       out_valid_q;
  logic [7:0] o_type_q;
  logic [5:0] o_len_q;
  logic [4:0] o_pos_q;
  logic [7:0] o_val_q;
  logic       o_has_q;
  logic       o_last_q;

  assign issue   = desc_valid_i && !pend_q && !out_valid_q;
  assign has_pay = (desc_i.frame_length != 8'd0);
  assign is_last = !has_pay || ((idx_q + 8'd1) == desc_i.frame_length);

  assign desc_pop_o = issue && is_last;
  assign re_o       = issue && has_pay;
  assign raddr_o    = {bank_i, idx_q[IW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        idx_q <= is_last ? 8'd0 : idx_q + 8'd1;
      end
      pend_q <= issue;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p_type_q <= desc_i.frame_type;
      p_len_q  <= desc_i.frame_length[5:0];
      p_pos_q  <= idx_q[4:0];
      p_has_q  <= has_pay;
      p_last_q <= is_last;
    end
    if (pend_q) begin
      o_type_q <= p_type_q;
      o_len_q  <= p_len_q;
      o_pos_q  <= p_pos_q;
      o_val_q  <= p_has_q ? rdata_i : 8'd0;
      o_has_q  <= p_has_q;
      o_last_q <= p_last_q;
    end
  end

  assign empty_o         = !out_valid_q;
  assign frame_type_o    = o_type_q;
  assign frame_length_o  = o_len_q;
  assign byte_position_o = o_pos_q;
  assign payload_value_o = o_val_q;
  assign has_payload_o   = o_has_q;
  assign last_o          = o_last_q;

endmodule

>>> sv/srx_checker.sv
// Port-level checker of the frame receiver and its bind to the top level.
module srx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] frame_type_o,
  input logic [5:0] frame_length_o,
  input logic [4:0] byte_position_o,
  input logic [7:0] payload_value_o,
  input logic       has_payload_o,
  input logic       last_o
);

  // While reset is held, nothing is waiting on either side.
  assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queues not empty during reset");

  // An empty frame is a single result with zero length, position and value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_payload_o) |->
      (last_o && frame_length_o == 6'd0 && byte_position_o == 5'd0 &&
       payload_value_o == 8'd0))
    else $error("malformed empty-frame result");

  // Within a frame, results arrive in position order with the same header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && has_payload_o && !last_o) |=>
      (empty || (has_payload_o && frame_type_o == $past(frame_type_o) &&
                 frame_length_o == $past(frame_length_o) &&
                 byte_position_o == 5'($past(byte_position_o) + 5'd1))))
    else $error("frame results out of order");

  // A waiting result is held until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=>
      (!empty && $stable(payload_value_o) && $stable(last_o) && $stable(byte_position_o)))
    else $error("waiting result changed");

endmodule

bind sync_len_type_crc8_frame_receiver srx_checker u_srx_checker (.*);
